// ===== src/svpm_pkg.sv =====
// ---------------------------------------------------------------------------
// svpm_pkg: shared types and constants of the sample voice player mixer
// Command codes, status codes and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none
package svpm_pkg;
  localparam int DefNumSlots   = 36;
  localparam int DefNumVoices  = 8;
  localparam int DefSampleWords = 65536;

  localparam logic [16:0] MaxLen = 17'h10000;
  localparam logic signed [19:0] SatMin = -20'sd32768;
  localparam logic signed [19:0] SatMax = 20'sd32767;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_DEFINE  = 2'd1,
    CMD_TRIGGER = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ===== src/svpm_sample_ram.sv =====
// ---------------------------------------------------------------------------
// svpm_sample_ram: sample word memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module svpm_sample_ram #(
  parameter int Words = 65536,
  parameter int AW = $clog2(Words)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata
);
  logic [15:0] mem [Words];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/sample_voice_player_mixer.sv =====
// ---------------------------------------------------------------------------
// sample_voice_player_mixer: multi-voice PCM sample player and mixer
// Plays stored sample slots on a set of voices and mixes them onto game audio.
// ---------------------------------------------------------------------------
//  channel | handshake     | payload
//  --------+---------------+------------------------------------------------
//  command | start / busy  | cmd slot_index sample_address sample_value
//          |               | slot_length slot_enable slot_sustained game_sample
//  result  | done (strobe) | status mixed_sample clipped active_voices
//          |               | voice_used clipped_total trigger_latency
//
// Write and define run execute then done; an accepted trigger adds a stop
// step and walks the voices one per step; tick does a check and an add per
// voice around the sample RAM read, plus a re-check per wrapping voice.
// done follows the last busy cycle with busy already low; results cannot stall.
// Reset clears all slot and voice state; the sample RAM is not cleared.
`default_nettype none
module sample_voice_player_mixer
  import svpm_pkg::*;
#(
  parameter int NUM_SLOTS    = DefNumSlots,
  parameter int NUM_VOICES   = DefNumVoices,
  parameter int SAMPLE_WORDS = DefSampleWords
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic [5:0]         slot_index,
  input  wire logic [15:0]        sample_address,
  input  wire logic signed [15:0] sample_value,
  input  wire logic [16:0]        slot_length,
  input  wire logic               slot_enable,
  input  wire logic               slot_sustained,
  input  wire logic signed [15:0] game_sample,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [15:0]      mixed_sample,
  output logic                    clipped,
  output logic [3:0]              active_voices,
  output logic [2:0]              voice_used,
  output logic [31:0]             clipped_total,
  output logic [31:0]             trigger_latency
);
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int SumW = 16 + $clog2(NUM_VOICES + 1);
  localparam logic [VW:0] LastVoice = (VW + 1)'(NUM_VOICES - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_STOP  = 7'b0000100,
    S_PICK  = 7'b0001000,
    S_TCHK  = 7'b0010000,
    S_TADD  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] size;
    logic        en;
    logic        sus;
  } slot_ent_t;

  state_t state;

  // latched item
  logic [1:0]         r_cmd;
  logic [5:0]         r_slot;
  logic [15:0]        r_addr;
  logic [15:0]        r_value;
  logic [16:0]        r_len;
  logic               r_en, r_sus;
  logic signed [15:0] r_game;

  // slot table: one registered read a cycle; an entry never defined reads as zero
  slot_ent_t            slot_tab [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;
  slot_ent_t            slot_rd, slot_cur, slot_wdata;
  logic                 slot_rd_v;
  logic [SW-1:0]        slot_raddr;
  logic                 slot_we;
  logic                 t_sus;

  // voice state
  logic [NUM_VOICES-1:0] voice_active, voice_looping;
  logic [SW-1:0] voice_slot     [NUM_VOICES];
  logic [16:0]   voice_position [NUM_VOICES];
  logic [31:0]   voice_age      [NUM_VOICES];

  logic [31:0] serial_counter, ticks_since_trigger, first_latency, clip_count;
  logic        waiting_first;

  // sequencer scratch
  logic [VW-1:0] vidx, vidx_nx;
  logic          found_idle, found_old;
  logic [VW-1:0] choice;
  logic [31:0]   best;
  logic signed [SumW-1:0] sum;
  logic          contributed;

  logic [15:0]   ram_rdata;
  logic [AW-1:0] ram_raddr;
  logic          slot_ok;
  logic [SW-1:0] slot_sel;

  assign slot_ok  = {1'b0, r_slot} < 7'(NUM_SLOTS);
  assign slot_sel = SW'(r_slot);
  assign busy     = (state != S_IDLE);
  assign vidx_nx  = vidx + VW'(1);

  // the slot needed next cycle: the new item's slot, else the voice checked next
  always_comb begin
    if (state == S_IDLE) slot_raddr = SW'(slot_index);
    else if (state == S_TADD) slot_raddr = voice_slot[vidx_nx];
    else slot_raddr = voice_slot[vidx];
  end

  assign slot_cur   = slot_rd_v ? slot_rd : '0;
  assign slot_we    = (state == S_EXEC) && (r_cmd == CMD_DEFINE) && slot_ok;
  assign slot_wdata = '{base: r_addr, size: (r_len > MaxLen) ? MaxLen : r_len,
                        en: r_en, sus: r_sus};

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_tab[slot_sel] <= slot_wdata;
    end
    slot_rd   <= slot_tab[slot_raddr];
    slot_rd_v <= slot_valid[slot_raddr];
  end

  // current voice lookups, one shared path per step
  logic [SW-1:0] cur_slot;
  logic [16:0]   cur_size, cur_pos;
  logic [15:0]   cur_base;
  logic          cur_slot_ok;
  logic [31:0]   cur_delta;
  assign cur_slot    = voice_slot[vidx];
  assign cur_slot_ok = {1'b0, cur_slot} < (SW + 1)'(NUM_SLOTS);
  assign cur_size    = cur_slot_ok ? slot_cur.size : 17'd0;
  assign cur_base    = cur_slot_ok ? slot_cur.base : 16'd0;
  assign cur_pos     = voice_position[vidx];
  assign cur_delta   = serial_counter - voice_age[vidx];

  logic [15:0] rd_word;
  assign rd_word   = cur_base + cur_pos[15:0];
  assign ram_raddr = AW'(rd_word);

  svpm_sample_ram #(.Words(SAMPLE_WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (state == S_EXEC && r_cmd == CMD_WRITE),
    .waddr (AW'(r_addr)),
    .wdata (r_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CW-1:0] act_cnt;
  always_comb begin
    act_cnt = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      act_cnt = act_cnt + CW'(voice_active[i]);
    end
  end

  logic last_v;
  assign last_v = ({1'b0, vidx} == LastVoice);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      voice_active  <= '0;
      voice_looping <= '0;
      serial_counter <= '0;
      ticks_since_trigger <= '0;
      first_latency <= '1;
      clip_count <= '0;
      waiting_first <= 1'b0;
      slot_valid <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        voice_slot[i] <= '0;
        voice_position[i] <= '0;
        voice_age[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r_cmd <= cmd; r_slot <= slot_index; r_addr <= sample_address;
            r_value <= sample_value; r_len <= slot_length; r_en <= slot_enable;
            r_sus <= slot_sustained; r_game <= game_sample;
            vidx <= '0; found_idle <= 1'b0; found_old <= 1'b0;
            choice <= '0; best <= '0; contributed <= 1'b0;
            sum <= SumW'(game_sample);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= ST_DONE; mixed_sample <= '0; clipped <= 1'b0;
          voice_used <= '0;
          state <= S_DONE;
          unique case (r_cmd)
            CMD_WRITE: ;
            CMD_DEFINE: begin
              if (!slot_ok) status <= ST_BAD_SLOT;
              else slot_valid[slot_sel] <= 1'b1;
            end
            CMD_TRIGGER: begin
              if (!slot_ok) status <= ST_BAD_SLOT;
              else if (slot_cur.size == 17'd0 || !slot_cur.en)
                status <= ST_REFUSED;
              else begin
                t_sus <= slot_cur.sus;
                state <= S_STOP;
              end
            end
            default: state <= S_TCHK;
          endcase
        end
        S_STOP: begin
          // sustained slot drops all looping voices at once
          if (t_sus) voice_active <= voice_active & ~voice_looping;
          state <= S_PICK;
        end
        S_PICK: begin
          if (!found_idle) begin
            if (!voice_active[vidx]) begin
              found_idle <= 1'b1; choice <= vidx;
            end else if (!voice_looping[vidx] &&
                         (!found_old || cur_delta > best)) begin
              found_old <= 1'b1; best <= cur_delta; choice <= vidx;
            end
          end
          if (last_v) begin
            state <= S_DONE;
          end else begin
            vidx <= vidx_nx;
          end
        end
        S_TCHK: begin
          // check a voice and issue its RAM read
          if (voice_active[vidx]) begin
            if (!cur_slot_ok || cur_size == 17'd0) begin
              voice_active[vidx] <= 1'b0;
              state <= S_TADD;
            end else if (cur_pos >= cur_size && !voice_looping[vidx]) begin
              voice_active[vidx] <= 1'b0;
              state <= S_TADD;
            end else if (cur_pos >= cur_size) begin
              voice_position[vidx] <= '0;  // re-read next cycle from zero
            end else begin
              state <= S_TADD;
            end
          end else begin
            state <= S_TADD;
          end
        end
        S_TADD: begin
          if (voice_active[vidx]) begin
            sum <= sum + SumW'(signed'(ram_rdata));
            voice_position[vidx] <= cur_pos + 17'd1;
            contributed <= 1'b1;
          end
          if (last_v) state <= S_DONE;
          else begin
            vidx <= vidx_nx;
            state <= S_TCHK;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (r_cmd == CMD_TRIGGER && status == ST_DONE) begin
            voice_active[choice]   <= 1'b1;
            voice_slot[choice]     <= slot_sel;
            voice_looping[choice]  <= t_sus;
            voice_position[choice] <= '0;
            voice_age[choice]      <= serial_counter + 32'd1;
            serial_counter <= serial_counter + 32'd1;
            waiting_first <= 1'b1;
            ticks_since_trigger <= '0;
            voice_used <= 3'(choice);
          end else if (r_cmd == CMD_TICK) begin
            if (contributed && waiting_first) begin
              first_latency <= ticks_since_trigger;
              waiting_first <= 1'b0;
            end else if (waiting_first && ticks_since_trigger != '1) begin
              ticks_since_trigger <= ticks_since_trigger + 32'd1;
            end
            if (sum < SatMin) begin
              mixed_sample <= 16'sh8000; clipped <= 1'b1;
            end else if (sum > SatMax) begin
              mixed_sample <= 16'sh7fff; clipped <= 1'b1;
            end else begin
              mixed_sample <= sum[15:0];
            end
            if ((sum < SatMin || sum > SatMax) && clip_count != '1)
              clip_count <= clip_count + 32'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // voice state has settled by the done cycle
  assign active_voices   = 4'(act_cnt);
  assign clipped_total   = clip_count;
  assign trigger_latency = first_latency;

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done lasted more than one cycle");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");
  a_no_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy && !done) else $error("accept did not go busy");
  a_act_range: assert property (@(posedge clk) disable iff (rst)
    $countones(voice_active) <= NUM_VOICES) else $error("voice count off");
`endif
endmodule
`default_nettype wire
